// ----- design/byte_ring_fifo_with_linear_region_assert.svh -----
// ----------------------------------------------------------------------------
// Byte ring FIFO assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BYTE_RING_FIFO_WITH_LINEAR_REGION_ASSERT_SVH
`define BYTE_RING_FIFO_WITH_LINEAR_REGION_ASSERT_SVH

// condition holds at every clock edge
`define BRF_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("brf: invariant violated");

// consequent holds in the same cycle as the antecedent
`define BRF_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brf: same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define BRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brf: next-cycle check failed");

`endif

// ----- design/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// Byte ring FIFO package
// Operation codes, controller states and the result bundle.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 9;
    localparam int INDEX_W = 8;
    localparam int CFG_W   = 4;

    localparam logic [CFG_W-1:0] SIZE_LOG2_RESET = 4'd8;

    typedef enum logic [1:0] {
        FUNC_PUT     = 2'd0,
        FUNC_GET     = 2'd1,
        FUNC_REGION  = 2'd2,
        FUNC_ADVANCE = 2'd3
    } func_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_READ = 1'b1
    } state_t;

    typedef struct packed {
        logic               ok;
        logic [INDEX_W-1:0] region_index;
        logic [LEN_W-1:0]   region_count;
        logic [LEN_W-1:0]   used_count;
        logic [LEN_W-1:0]   free_count;
    } op_res_t;

endpackage

// ----- design/brf_ram.sv -----
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic              re,
    input  logic [ADDR_W-1:0] addr,
    input  logic [WIDTH-1:0]  wdata,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/brf_ptr.sv -----
// ----------------------------------------------------------------------------
// Byte ring FIFO pointer unit
// Holds head, tail and ring size; works out occupancy, store access and the
// result fields of each operation.
// ----------------------------------------------------------------------------
`include "byte_ring_fifo_with_linear_region_assert.svh"

module brf_ptr
    import brf_pkg::*;
#(
    parameter int DEPTH = 256,
    localparam int MAX_LOG2 = $clog2(DEPTH + 1) - 1,
    localparam int IDX_W = MAX_LOG2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_size_log2,
    input  logic             op_fire,
    input  func_t            func,
    input  logic [LEN_W-1:0] advance_len,
    output logic             ram_we,
    output logic             ram_re,
    output logic [IDX_W-1:0] ram_addr,
    output op_res_t          res
);

    localparam int PTR_W = MAX_LOG2 + 1;
    localparam int CNT_W = MAX_LOG2 + 1;
    localparam int LOG_W = $clog2(MAX_LOG2 + 1);
    localparam int CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [CFG_W-1:0] size_log2_reg;
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;

    logic [LOG_W-1:0] eff_log2;
    logic [CNT_W-1:0] size;
    logic [IDX_W-1:0] imask;
    logic [CNT_W-1:0] used;
    logic [CNT_W-1:0] used_after;
    logic [IDX_W-1:0] head_idx;
    logic [IDX_W-1:0] tail_idx;
    logic [CNT_W-1:0] span;
    logic             adv_ok;
    logic [CNT_W-1:0] adv_amt;
    logic             ok;
    logic [IDX_W-1:0] ridx;
    logic [CNT_W-1:0] rcnt;

    // oversized setting saturates to the largest ring the store holds
    assign eff_log2 = (32'(size_log2_reg) > MAX_LOG2) ? LOG_W'(MAX_LOG2)
                                                      : LOG_W'(size_log2_reg);
    assign size     = CNT_W'(1) << eff_log2;
    assign imask    = IDX_W'(size - CNT_W'(1));
    assign used     = head_reg - tail_reg;
    assign head_idx = head_reg[IDX_W-1:0] & imask;
    assign tail_idx = tail_reg[IDX_W-1:0] & imask;
    assign span     = size - CNT_W'(tail_idx);
    assign adv_ok   = CMP_W'(advance_len) <= CMP_W'(used);
    assign adv_amt  = adv_ok ? CNT_W'(advance_len) : used;

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        used_after = used;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_addr   = head_idx;
        ok         = 1'b0;
        ridx       = '0;
        rcnt       = '0;
        if (op_fire)
        begin
            unique case (func)
                FUNC_PUT:
                begin
                    if (used < size)
                    begin
                        ram_we     = 1'b1;
                        head_next  = head_reg + PTR_W'(1);
                        used_after = used + CNT_W'(1);
                        ok         = 1'b1;
                    end
                end
                FUNC_GET:
                begin
                    ram_addr = tail_idx;
                    if (used != '0)
                    begin
                        ram_re     = 1'b1;
                        tail_next  = tail_reg + PTR_W'(1);
                        used_after = used - CNT_W'(1);
                        ok         = 1'b1;
                    end
                end
                FUNC_REGION:
                begin
                    if (used != '0)
                    begin
                        ok   = 1'b1;
                        ridx = tail_idx;
                        rcnt = (used < span) ? used : span;
                    end
                end
                FUNC_ADVANCE:
                begin
                    ok         = adv_ok;
                    tail_next  = tail_reg + PTR_W'(adv_amt);
                    used_after = used - adv_amt;
                end
                default:
                begin
                    ok = 1'b0;
                end
            endcase
        end
    end

    assign res.ok           = ok;
    assign res.region_index = INDEX_W'(ridx);
    assign res.region_count = LEN_W'(rcnt);
    assign res.used_count   = LEN_W'(used_after);
    assign res.free_count   = LEN_W'(size - used_after);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_log2_reg <= SIZE_LOG2_RESET;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else if (cfg_we)
        begin
            // resizing empties the ring
            size_log2_reg <= cfg_size_log2;
            head_reg      <= '0;
            tail_reg      <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    `BRF_ASSERT_ALWAYS(a_used_within_size, used <= size)
    `BRF_ASSERT_NEXT(a_cfg_empties, cfg_we, used == '0)
    `BRF_ASSERT_NEXT(a_head_only_on_put, op_fire && !cfg_we && !ram_we, $stable(head_reg))

endmodule

// ----- design/byte_ring_fifo_with_linear_region.sv -----
// ----------------------------------------------------------------------------
// Byte ring FIFO with linear region query
// Power-of-two ring FIFO on a single-port byte RAM with put, get, region
// query and tail advance operations.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to issue one operation; its result appears
// on the result ports for exactly one cycle with done high, and must be
// captured then since there is no back-pressure. Put, region query, advance
// and a get on an empty ring finish without a wait: done follows the accepting
// edge and busy stays low, so a new operation can go in every cycle. A
// successful get waits on the RAM: busy is high for one cycle while the
// registered RAM read completes, then done strobes with the byte.
// Writing size_log2 through the cfg channel (only while idle and start is
// low, so an operation and a resize never share an edge) also empties the
// ring. No clearing pass runs after reset.
`include "byte_ring_fifo_with_linear_region_assert.svh"

module byte_ring_fifo_with_linear_region
    import brf_pkg::*;
#(
    parameter int DEPTH = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         func,
    input  logic [DATA_W-1:0]  data_in,
    input  logic [LEN_W-1:0]   advance_len,
    output logic               done,
    output logic               ok,
    output logic [DATA_W-1:0]  data_out,
    output logic [INDEX_W-1:0] region_index,
    output logic [LEN_W-1:0]   region_count,
    output logic [LEN_W-1:0]   used_count,
    output logic [LEN_W-1:0]   free_count
);

    localparam int MAX_LOG2 = $clog2(DEPTH + 1) - 1;
    localparam int IDX_W    = MAX_LOG2;
    localparam int RAM_D    = 1 << MAX_LOG2;

    state_t             state_reg, state_next;
    logic               done_reg, done_next;
    op_res_t            res_reg, res_next;
    logic [DATA_W-1:0]  data_out_reg, data_out_next;

    logic               op_fire;
    logic               cfg_we;
    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_addr;
    logic [DATA_W-1:0]  ram_rdata;
    op_res_t            op_res;

    assign busy      = (state_reg != ST_IDLE);
    // a resize waits while an operation is being issued
    assign cfg_ready = (state_reg == ST_IDLE) && !start;
    assign op_fire   = start && !busy;
    assign cfg_we    = cfg_valid && cfg_ready;

    brf_ptr #(
        .DEPTH (DEPTH)
    ) u_ptr (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_size_log2 (cfg_data),
        .op_fire       (op_fire),
        .func          (func_t'(func)),
        .advance_len   (advance_len),
        .ram_we        (ram_we),
        .ram_re        (ram_re),
        .ram_addr      (ram_addr),
        .res           (op_res)
    );

    brf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_D)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (ram_addr),
        .wdata (data_in),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next    = state_reg;
        done_next     = 1'b0;
        res_next      = res_reg;
        data_out_next = data_out_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (op_fire)
                begin
                    res_next      = op_res;
                    data_out_next = '0;
                    if (ram_re)
                    begin
                        state_next = ST_READ;
                    end
                    else
                    begin
                        done_next = 1'b1;
                    end
                end
            end
            ST_READ:
            begin
                data_out_next = ram_rdata;
                done_next     = 1'b1;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg      <= res_next;
        data_out_reg <= data_out_next;
    end

    assign done         = done_reg;
    assign ok           = res_reg.ok;
    assign data_out     = data_out_reg;
    assign region_index = res_reg.region_index;
    assign region_count = res_reg.region_count;
    assign used_count   = res_reg.used_count;
    assign free_count   = res_reg.free_count;

    `BRF_ASSERT_NEXT(a_read_issues_wait, op_fire && ram_re, state_reg == ST_READ && !done_reg)
    `BRF_ASSERT_NEXT(a_read_completes, state_reg == ST_READ, done_reg && state_reg == ST_IDLE)
    `BRF_ASSERT_SAME(a_no_cfg_mid_read, state_reg == ST_READ, !cfg_ready && !ram_we)

endmodule
